[src/grbsp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grbsp_pkg
// Shared types and constants of the return grouping block.
// ----------------------------------------------------------------------------
package grbsp_pkg;

  localparam int MAX_GROUP_DEFAULT    = 15;
  localparam int PAYLOAD_BITS_DEFAULT = 64;

  localparam int COORD_W     = 32;
  localparam int RET_W       = 4;
  localparam int TIME_W      = 63;
  localparam int STEP_W      = 32;
  localparam int CFG_DATA_W  = 63;
  localparam int CFG_INDEX_W = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [TIME_W-1:0] TIME_START_RESET = 63'd100000000000000000;
  localparam logic [STEP_W-1:0] TIME_STEP_RESET  = 32'd1000;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TIME_START = 1'b0,
    REG_TIME_STEP  = 1'b1
  } grbsp_reg_t;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_START  = 2'd1,
    OP_FLUSH  = 2'd2
  } grbsp_op_t;

  typedef struct packed {
    grbsp_op_t op;
    logic      cut;
  } grbsp_cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } grbsp_state_t;

endpackage
`default_nettype wire

[src/grbsp_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grbsp_ifs
// Valid/ready channels for incoming points and emitted returns.
// ----------------------------------------------------------------------------
interface grbsp_point_if #(
  parameter int PAYLOAD_BITS = grbsp_pkg::PAYLOAD_BITS_DEFAULT
);
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [PAYLOAD_BITS-1:0]          point_payload;
  logic signed [grbsp_pkg::COORD_W-1:0] sensor_x_raw;
  logic signed [grbsp_pkg::COORD_W-1:0] sensor_y_raw;
  logic signed [grbsp_pkg::COORD_W-1:0] sensor_z_raw;

  modport source (output valid, kind, point_payload, sensor_x_raw, sensor_y_raw,
                  sensor_z_raw, input ready);
  modport sink (input valid, kind, point_payload, sensor_x_raw, sensor_y_raw,
                sensor_z_raw, output ready);
endinterface

interface grbsp_return_if #(
  parameter int PAYLOAD_BITS = grbsp_pkg::PAYLOAD_BITS_DEFAULT
);
  logic                           valid;
  logic                           ready;
  logic [PAYLOAD_BITS-1:0]        out_payload;
  logic [grbsp_pkg::RET_W-1:0]    return_index;
  logic [grbsp_pkg::RET_W-1:0]    return_total;
  logic [grbsp_pkg::TIME_W-1:0]   stamp_ns;
  logic                           last_of_run;
  logic                           forced_split;

  modport source (output valid, out_payload, return_index, return_total, stamp_ns,
                  last_of_run, forced_split, input ready);
  modport sink (input valid, out_payload, return_index, return_total, stamp_ns,
                last_of_run, forced_split, output ready);
endinterface
`default_nettype wire

[src/group_returns_by_sensor_position.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// group_returns_by_sensor_position
// Groups consecutive lidar points of one pulse and numbers their returns.
// ----------------------------------------------------------------------------
// A point that joins the open group is appended to the group buffer. A point
// that opens a new group, or an end-of-stream word, releases the held group
// of n points as n result words, one per cycle while the sink takes them,
// and the group is closed with its last word. The rate is set by the back
// end, which reads one entry of the group buffer per cycle while the sink
// takes them; a two-word queue lets the input side keep accepting while a
// group is being emitted. Writing time_start_ns also reloads the running
// timestamp. The user must write configuration while idle; it is not enforced.
// ----------------------------------------------------------------------------
module group_returns_by_sensor_position #(
  parameter int MAX_GROUP    = grbsp_pkg::MAX_GROUP_DEFAULT,
  parameter int PAYLOAD_BITS = grbsp_pkg::PAYLOAD_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  grbsp_point_if.sink                            points,
  grbsp_return_if.source                         returns,
  input  wire logic                              cfg_we,
  input  wire logic [grbsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [grbsp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int Q_W = $bits(grbsp_pkg::grbsp_cmd_t) + PAYLOAD_BITS;

  logic                    q_push, q_pop, q_full, q_not_empty;
  grbsp_pkg::grbsp_cmd_t   push_cmd, head_cmd;
  logic [PAYLOAD_BITS-1:0] push_payload, head_payload;
  logic [Q_W-1:0]          q_rd;

  grbsp_front #(
    .MAX_GROUP    (MAX_GROUP),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .points    (points),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .q_payload (push_payload)
  );

  grbsp_fifo #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_data   ({push_cmd, push_payload}),
    .pop       (q_pop),
    .rd_data   (q_rd),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  assign {head_cmd, head_payload} = q_rd;

  grbsp_back #(
    .MAX_GROUP    (MAX_GROUP),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_not_empty),
    .head_cmd     (head_cmd),
    .head_payload (head_payload),
    .pop          (q_pop),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .returns      (returns)
  );

endmodule
`default_nettype wire

[src/grbsp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grbsp_front
// Accepts points, tracks the open pulse position and classifies each word.
// ----------------------------------------------------------------------------
module grbsp_front #(
  parameter int MAX_GROUP    = grbsp_pkg::MAX_GROUP_DEFAULT,
  parameter int PAYLOAD_BITS = grbsp_pkg::PAYLOAD_BITS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  grbsp_point_if.sink            points,
  input  wire logic              q_full,
  output logic                   q_push,
  output grbsp_pkg::grbsp_cmd_t  q_cmd,
  output logic [PAYLOAD_BITS-1:0] q_payload
);

  localparam int CNT_W = $clog2(MAX_GROUP + 1);

  logic [grbsp_pkg::COORD_W-1:0] key_x, key_y, key_z;
  logic                          key_valid;
  logic [CNT_W-1:0]              fcount;
  logic                          match;

  assign points.ready = !q_full;
  assign q_push       = points.valid && !q_full;
  assign q_payload    = points.point_payload;

  assign match = key_valid && (points.sensor_x_raw == key_x) &&
                 (points.sensor_y_raw == key_y) && (points.sensor_z_raw == key_z);

  always_comb begin
    if (points.kind == grbsp_pkg::KIND_FLUSH) begin
      q_cmd = '{op: grbsp_pkg::OP_FLUSH, cut: 1'b0};
    end else if (match && fcount < CNT_W'(MAX_GROUP)) begin
      q_cmd = '{op: grbsp_pkg::OP_APPEND, cut: 1'b0};
    end else begin
      q_cmd = '{op: grbsp_pkg::OP_START, cut: match};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
      fcount    <= '0;
      key_x     <= '0;
      key_y     <= '0;
      key_z     <= '0;
    end else if (q_push) begin
      if (points.kind == grbsp_pkg::KIND_FLUSH) begin
        key_valid <= 1'b0;
        fcount    <= '0;
      end else if (q_cmd.op == grbsp_pkg::OP_APPEND) begin
        fcount <= fcount + 1'b1;
      end else begin
        fcount    <= CNT_W'(1);
        key_valid <= 1'b1;
        key_x     <= points.sensor_x_raw;
        key_y     <= points.sensor_y_raw;
        key_z     <= points.sensor_z_raw;
      end
    end
  end

endmodule
`default_nettype wire

[src/grbsp_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grbsp_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module grbsp_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  full,
  output logic                  not_empty
);

  localparam int DEPTH = grbsp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = (fill == CNT_W'(DEPTH));
  assign not_empty = (fill != '0);
  assign rd_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[src/grbsp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grbsp_back
// Holds the group buffer and the time base, and emits buffered groups.
// ----------------------------------------------------------------------------
module grbsp_back #(
  parameter int MAX_GROUP    = grbsp_pkg::MAX_GROUP_DEFAULT,
  parameter int PAYLOAD_BITS = grbsp_pkg::PAYLOAD_BITS_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 head_valid,
  input  wire grbsp_pkg::grbsp_cmd_t                head_cmd,
  input  wire logic [PAYLOAD_BITS-1:0]              head_payload,
  output logic                                      pop,
  input  wire logic                                 cfg_we,
  input  wire logic [grbsp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [grbsp_pkg::CFG_DATA_W-1:0]     cfg_data,
  grbsp_return_if.source                            returns
);

  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam int IDX_W = $clog2(MAX_GROUP);

  grbsp_pkg::grbsp_state_t state, state_next;

  logic [PAYLOAD_BITS-1:0]        buffer [MAX_GROUP];
  logic [CNT_W-1:0]               count;
  logic [IDX_W-1:0]               idx;
  logic [grbsp_pkg::TIME_W-1:0]   time_acc;
  logic [grbsp_pkg::STEP_W-1:0]   time_step;

  logic                           out_valid;
  logic [PAYLOAD_BITS-1:0]        out_payload;
  logic [grbsp_pkg::RET_W-1:0]    out_index, out_total;
  logic [grbsp_pkg::TIME_W-1:0]   out_stamp;
  logic                           out_last, out_cut;

  logic             out_free, emit, finish, do_append, last;
  logic [CNT_W-1:0] idx_ext;

  assign out_free = !out_valid || returns.ready;
  assign idx_ext  = CNT_W'(idx);
  assign last     = (idx_ext + 1'b1) == count;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    finish     = 1'b0;
    do_append  = 1'b0;
    unique case (state)
      grbsp_pkg::ST_IDLE: begin
        if (head_valid) begin
          if (head_cmd.op == grbsp_pkg::OP_APPEND) begin
            do_append = 1'b1;
            pop       = 1'b1;
          end else if (count == '0) begin
            finish = 1'b1;
            pop    = 1'b1;
          end else begin
            state_next = grbsp_pkg::ST_EMIT;
          end
        end
      end
      grbsp_pkg::ST_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (last) begin
            finish     = 1'b1;
            pop        = 1'b1;
            state_next = grbsp_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = grbsp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grbsp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_append) begin
      buffer[count[IDX_W-1:0]] <= head_payload;
    end else if (finish && head_cmd.op == grbsp_pkg::OP_START) begin
      buffer[0] <= head_payload;
    end
    if (emit) begin
      out_payload <= buffer[idx];
      out_index   <= grbsp_pkg::RET_W'(idx_ext + 1'b1);
      out_total   <= grbsp_pkg::RET_W'(count);
      out_stamp   <= time_acc;
      out_last    <= last;
      out_cut     <= head_cmd.cut;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
      time_acc  <= grbsp_pkg::TIME_START_RESET;
      time_step <= grbsp_pkg::TIME_STEP_RESET;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        idx       <= last ? '0 : idx + 1'b1;
      end else if (returns.ready) begin
        out_valid <= 1'b0;
      end
      if (do_append) begin
        count <= count + 1'b1;
      end
      if (finish) begin
        count <= (head_cmd.op == grbsp_pkg::OP_START) ? CNT_W'(1) : '0;
        if (count != '0) begin
          time_acc <= time_acc + grbsp_pkg::TIME_W'(time_step);
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          grbsp_pkg::REG_TIME_START: time_acc  <= cfg_data;
          grbsp_pkg::REG_TIME_STEP:  time_step <= cfg_data[grbsp_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign returns.valid        = out_valid;
  assign returns.out_payload  = out_payload;
  assign returns.return_index = out_index;
  assign returns.return_total = out_total;
  assign returns.stamp_ns     = out_stamp;
  assign returns.last_of_run  = out_last;
  assign returns.forced_split = out_cut;

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    state == grbsp_pkg::ST_EMIT |-> idx_ext < count)
    else $error("emit index runs past the group size");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_GROUP))
    else $error("group count exceeds the buffer depth");

  a_last_ends_group: assert property (@(posedge clk) disable iff (rst)
    emit && last |=> state == grbsp_pkg::ST_IDLE && idx == '0 && out_last)
    else $error("final word of a group did not close the emit pass");

endmodule
`default_nettype wire

[tb/return_grouping_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// return_grouping_check
// Watches the point, return and register channels of the return grouping
// block. Every accepted point word is run through a local model of the
// grouping, and the return words that it releases are queued. Each accepted
// return word is compared field by field with the oldest queued word. The
// number of failures and of queued words is handed to the testbench top.
// ----------------------------------------------------------------------------
module return_grouping_check import grbsp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  grbsp_point_if                 points,
  grbsp_return_if                returns,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);

  localparam int GROUP_DEPTH = MAX_GROUP_DEFAULT;
  localparam int PAYLOAD_W   = PAYLOAD_BITS_DEFAULT;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic [RET_W-1:0]     index;
    logic [RET_W-1:0]     total;
    logic [TIME_W-1:0]    stamp;
    logic                 last;
    logic                 split;
  } return_word_t;

  return_word_t         expected_returns[$];
  logic [PAYLOAD_W-1:0] held_payload [GROUP_DEPTH];
  int                   held_count;
  logic [COORD_W-1:0]   key_x;
  logic [COORD_W-1:0]   key_y;
  logic [COORD_W-1:0]   key_z;
  logic                 key_open;
  logic [TIME_W-1:0]    stamp_acc;
  logic [STEP_W-1:0]    step_ns;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
    end
  endtask

  function automatic void release_group(input logic cut);
    return_word_t w;
    for (int i = 0; i < held_count; i++) begin
      w.payload = held_payload[i];
      w.index   = RET_W'(i + 1);
      w.total   = RET_W'(held_count);
      w.stamp   = stamp_acc;
      w.last    = (i + 1 == held_count);
      w.split   = cut;
      expected_returns.push_back(w);
    end
    if (held_count > 0) begin
      stamp_acc = stamp_acc + TIME_W'(step_ns);
    end
    held_count = 0;
  endfunction

  function automatic void group_word(input logic kind, input logic [PAYLOAD_W-1:0] payload,
                                     input logic [COORD_W-1:0] x,
                                     input logic [COORD_W-1:0] y,
                                     input logic [COORD_W-1:0] z);
    if (kind == KIND_FLUSH) begin
      release_group(1'b0);
      key_open = 1'b0;
    end else if (key_open && x == key_x && y == key_y && z == key_z) begin
      if (held_count < GROUP_DEPTH) begin
        held_payload[held_count] = payload;
        held_count++;
      end else begin
        // A full buffer cuts the pulse; the point starts a new group.
        release_group(1'b1);
        held_payload[0] = payload;
        held_count = 1;
      end
    end else begin
      release_group(1'b0);
      key_x = x;
      key_y = y;
      key_z = z;
      key_open = 1'b1;
      held_payload[0] = payload;
      held_count = 1;
    end
  endfunction

  always @(posedge clk) begin : watch_channels
    return_word_t got;
    return_word_t want;
    if (rst) begin
      expected_returns.delete();
      held_count = 0;
      key_x = '0;
      key_y = '0;
      key_z = '0;
      key_open = 1'b0;
      stamp_acc = TIME_START_RESET;
      step_ns = TIME_STEP_RESET;
    end else begin
      if (returns.valid && returns.ready) begin
        got.payload = returns.out_payload;
        got.index   = returns.return_index;
        got.total   = returns.return_total;
        got.stamp   = returns.stamp_ns;
        got.last    = returns.last_of_run;
        got.split   = returns.forced_split;
        if (expected_returns.size() == 0) begin
          report_mismatch($sformatf("return word %0h arrived with none pending",
                                    got.payload));
        end else begin
          want = expected_returns.pop_front();
          compare_field("out_payload", got.payload, want.payload);
          compare_field("return_index", got.index, want.index);
          compare_field("return_total", got.total, want.total);
          compare_field("stamp_ns", got.stamp, want.stamp);
          compare_field("last_of_run", got.last, want.last);
          compare_field("forced_split", got.split, want.split);
        end
      end
      if (cfg_we) begin
        case (grbsp_reg_t'(cfg_index))
          REG_TIME_START: begin
            stamp_acc = cfg_data[TIME_W-1:0];
          end
          REG_TIME_STEP: begin
            step_ns = cfg_data[STEP_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (points.valid && points.ready) begin
        group_word(points.kind, points.point_payload, points.sensor_x_raw,
                   points.sensor_y_raw, points.sensor_z_raw);
      end
    end
    pending = expected_returns.size();
  end

endmodule

[tb/group_returns_by_sensor_position_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// group_returns_by_sensor_position_tb
// Drives point words and register writes into the return grouping block and
// gives the verdict from the checker's failure count. A directed opening
// covers the extreme fields, joined and broken pulses, a full buffer and
// flushes; random pulses follow under three register settings and three
// idling mixes, with one long receiver hold-off that stalls the input.
// ----------------------------------------------------------------------------
module group_returns_by_sensor_position_tb;
  import grbsp_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_CYCLES  = 40;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending;
  int                     cycle_count = 0;
  int                     send_idle_pct;
  int                     recv_idle_pct;
  int                     hold_req = 0;
  int                     hold_ack = 0;
  int                     hold_left = 0;
  logic [COORD_W-1:0]     last_x;
  logic [COORD_W-1:0]     last_y;
  logic [COORD_W-1:0]     last_z;

  grbsp_point_if  points ();
  grbsp_return_if returns ();

  group_returns_by_sensor_position DUT (
    .clk       (clk),
    .rst       (rst),
    .points    (points),
    .returns   (returns),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  return_grouping_check check_returns (
    .clk        (clk),
    .rst        (rst),
    .points     (points),
    .returns    (returns),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      returns.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      returns.ready <= 1'b0;
    end else begin
      returns.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic offer_word(input logic kind, input logic [63:0] payload,
                            input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      points.valid <= 1'b0;
    end
    @(negedge clk);
    points.valid <= 1'b1;
    points.kind <= kind;
    points.point_payload <= payload;
    points.sensor_x_raw <= x;
    points.sensor_y_raw <= y;
    points.sensor_z_raw <= z;
    do @(posedge clk); while (!points.ready);
  endtask

  task automatic send_flush();
    offer_word(KIND_FLUSH, {$urandom, $urandom}, $urandom, $urandom, $urandom);
  endtask

  task automatic send_pulse(input int n, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
    repeat (n) offer_word(KIND_POINT, {$urandom, $urandom}, x, y, z);
  endtask

  task automatic settle();
    @(negedge clk);
    points.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input grbsp_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_pulses(input int count);
    int sent;
    int pick;
    int size_pick;
    int n;
    logic [COORD_W-1:0] flip_mask;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_flush();
        sent++;
      end else begin
        if (pick >= 35) begin
          last_x = $urandom;
          last_y = $urandom;
          last_z = $urandom;
        end else if (pick >= 18) begin
          // A neighbor position that differs in a single bit of one axis.
          flip_mask = COORD_W'(1) << $urandom_range(COORD_W - 1);
          case ($urandom_range(2))
            0: last_x = last_x ^ flip_mask;
            1: last_y = last_y ^ flip_mask;
            default: last_z = last_z ^ flip_mask;
          endcase
        end
        size_pick = $urandom_range(9);
        if (size_pick < 6) begin
          n = $urandom_range(3, 1);
        end else if (size_pick < 9) begin
          n = $urandom_range(14, 4);
        end else begin
          n = $urandom_range(18, 15);
        end
        send_pulse(n, last_x, last_y, last_z);
        sent += n;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_TIME_START;
    cfg_data = '0;
    points.valid = 1'b0;
    points.kind = KIND_POINT;
    points.point_payload = '0;
    points.sensor_x_raw = '0;
    points.sensor_y_raw = '0;
    points.sensor_z_raw = '0;
    returns.ready = 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 72;
    last_x = '0;
    last_y = '0;
    last_z = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed opening under the reset register values.
    send_flush();
    offer_word(KIND_POINT, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    offer_word(KIND_POINT, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    offer_word(KIND_POINT, {$urandom, $urandom}, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000);
    send_flush();
    send_flush();
    last_x = $urandom;
    last_y = $urandom;
    last_z = $urandom;
    send_pulse(MAX_GROUP_DEFAULT + 1, last_x, last_y, last_z);
    send_pulse(1, last_x, last_y, last_z ^ 32'h1);
    send_pulse(1, last_x, last_y, last_z);
    send_flush();

    settle();
    write_register(REG_TIME_START, 63'h7FFF_FFFF_FFFF_F000);
    write_register(REG_TIME_STEP, {31'h2AAA_AAAA, 32'hFFFF_FFFF});
    random_pulses(20);

    settle();
    send_idle_pct = 72;
    recv_idle_pct = 22;
    write_register(REG_TIME_START, '0);
    write_register(REG_TIME_STEP, '0);
    random_pulses(12);
    settle();
    random_pulses(12);

    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(REG_TIME_START, CFG_DATA_W'({$urandom, $urandom}));
    write_register(REG_TIME_STEP, {31'h0, 32'($urandom)});
    hold_req = hold_req + 1;
    send_pulse(MAX_GROUP_DEFAULT, $urandom, $urandom, $urandom);
    send_pulse(MAX_GROUP_DEFAULT, $urandom, $urandom, $urandom);
    send_flush();
    random_pulses(20);
    send_flush();

    @(negedge clk);
    points.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
src/grbsp_pkg.sv
src/grbsp_ifs.sv
src/grbsp_front.sv
src/grbsp_fifo.sv
src/grbsp_back.sv
src/group_returns_by_sensor_position.sv
tb/return_grouping_check.sv
tb/group_returns_by_sensor_position_tb.sv
